### rtl/assert_macros.svh
// assertion macros used by the rtl of the clip cache point and area test
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising clock edge outside reset
`define CCPA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition must never be seen outside reset
`define CCPA_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

### rtl/ccpa_pkg.sv
// types, constants and helper functions of the clip cache point and area test
package ccpa_pkg;

  localparam int unsigned MaxRects    = 16;
  localparam int unsigned CoordW      = 16;
  localparam int unsigned RectIdxW    = $clog2(MaxRects);
  localparam int unsigned CountW      = $clog2(MaxRects + 1);
  localparam int unsigned RectIdxFldW = 4;
  localparam int unsigned RegionFldW  = 5;
  localparam int unsigned ScreenW     = 15;
  localparam int unsigned CfgIdxW     = 1;
  localparam int unsigned CfgDataW    = ScreenW;

  typedef logic signed [CoordW-1:0] coord_t;

  localparam coord_t CoordMin    = coord_t'({1'b1, {(CoordW-1){1'b0}}});
  localparam coord_t CoordMax    = coord_t'({1'b0, {(CoordW-1){1'b1}}});
  localparam coord_t CoordNegOne = coord_t'({CoordW{1'b1}});
  localparam coord_t CoordZero   = coord_t'(0);
  localparam coord_t CoordOne    = coord_t'(1);

  localparam logic [ScreenW-1:0] ScreenWidthRst  = ScreenW'(640);
  localparam logic [ScreenW-1:0] ScreenHeightRst = ScreenW'(480);

  typedef enum logic [1:0] {
    OP_WRITE_RECT = 2'd0,
    OP_SET_COUNT  = 2'd1,
    OP_CLIP_POINT = 2'd2,
    OP_CLIP_AREA  = 2'd3
  } req_op_e;

  typedef enum logic [1:0] {
    STATUS_INVISIBLE = 2'd0,
    STATUS_VISIBLE   = 2'd1,
    STATUS_PARTIAL   = 2'd2
  } clip_status_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_SCREEN_WIDTH  = 1'b0,
    CFG_SCREEN_HEIGHT = 1'b1
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD0,
    ST_CHECK,
    ST_HIT,
    ST_GROW,
    ST_DONE
  } ccpa_state_e;

  typedef struct packed {
    coord_t left;
    coord_t top;
    coord_t right;
    coord_t bottom;
  } rect_t;

  localparam int unsigned RectW = $bits(rect_t);

  typedef struct packed {
    coord_t min_x;
    coord_t min_y;
    coord_t max_x;
    coord_t max_y;
    logic   visible;
  } cache_t;

  localparam cache_t CacheReset = '{
    min_x: CoordMin, min_y: CoordMin, max_x: CoordMax, max_y: CoordMax, visible: 1'b0
  };

  // point inside the cached rectangle, all edges inclusive
  function automatic logic in_box(cache_t c, coord_t x, coord_t y);
    return (x >= c.min_x) && (x <= c.max_x) && (y >= c.min_y) && (y <= c.max_y);
  endfunction

  // decrement that sticks at the most negative coordinate
  function automatic coord_t sat_dec(coord_t v);
    return (v == CoordMin) ? CoordMin : coord_t'(v - CoordOne);
  endfunction

endpackage

### rtl/ccpa_if.sv
// request and response channel interfaces of the clip cache point and area test
interface ccpa_req_if;
  import ccpa_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [1:0]             req_type;
  logic [RectIdxFldW-1:0] rect_index;
  coord_t                 rect_left;
  coord_t                 rect_top;
  coord_t                 rect_right;
  coord_t                 rect_bottom;
  logic [RegionFldW-1:0]  region_count;
  coord_t                 x_first;
  coord_t                 y_first;
  coord_t                 x_second;
  coord_t                 y_second;

  modport source (
    output valid, req_type, rect_index, rect_left, rect_top, rect_right, rect_bottom,
           region_count, x_first, y_first, x_second, y_second,
    input  ready
  );

  modport sink (
    input  valid, req_type, rect_index, rect_left, rect_top, rect_right, rect_bottom,
           region_count, x_first, y_first, x_second, y_second,
    output ready
  );
endinterface

interface ccpa_rsp_if;
  logic       valid;
  logic       ready;
  logic [1:0] clip_status;

  modport source (output valid, clip_status, input ready);
  modport sink (input valid, clip_status, output ready);
endinterface

### rtl/ccpa_ram.sv
// generic simple dual-port ram with registered read
module ccpa_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### rtl/clip_cache_point_area_test.sv
// clip cache point and area test: rectangle table, cache and sequencer
// states from accept: a table write or zero count goes idle, done; a count load idle, load0,
//   done; a cached or off-screen test idle, check, done; a scan adds hit, and grow on a miss
// throughput: one word at a time, one table entry per cycle; an untaken result word holds
//   the block in its last state; reset: rst_ni clears count, cache (whole plane, invisible)
//   and screen size (640 x 480); the table is not cleared and must be written before use
`include "assert_macros.svh"

module clip_cache_point_area_test (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [ccpa_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [ccpa_pkg::CfgDataW-1:0]   cfg_wdata_i,
  ccpa_req_if.sink                        req_i,
  ccpa_rsp_if.source                      rsp_o
);
  import ccpa_pkg::*;

  // sequencer state
  ccpa_state_e state_q, state_d;

  // captured request word
  req_op_e op_q;
  coord_t  x_q, y_q, x2_q, y2_q;

  // architectural state
  logic [CountW-1:0]  count_q, count_d;
  cache_t             cache_q, cache_d;
  logic [ScreenW-1:0] width_q, height_q;

  // scan pointer and read-pending flag for the table ram
  logic [CountW-1:0] ptr_q, ptr_d;
  logic              pend_q, pend_d;

  // output register
  logic         out_valid_q, out_valid_d;
  clip_status_e out_status_q, out_status_d;

  // table ram ports
  logic                ram_we;
  logic [RectIdxW-1:0] ram_waddr, ram_raddr;
  rect_t               ram_wdata, rd_rect;

  logic              acc, out_free, load_out, issue;
  logic [CountW-1:0] cnt_sat;
  logic              cache_hit, off_screen, step_hit;
  coord_t            scr_w, scr_h;
  cache_t            grown;

  assign acc      = req_i.valid && req_i.ready;
  assign out_free = !out_valid_q || rsp_o.ready;
  assign req_i.ready = (state_q == ST_IDLE);

  // count written by a set-count word, clamped to the table size
  assign cnt_sat = (int'(req_i.region_count) > MaxRects) ? CountW'(MaxRects)
                                                         : CountW'(req_i.region_count);

  // screen size as signed coordinates
  assign scr_w = coord_t'({1'b0, width_q});
  assign scr_h = coord_t'({1'b0, height_q});

  assign cache_hit  = in_box(cache_q, x_q, y_q);
  assign off_screen = x_q[CoordW-1] || y_q[CoordW-1] || (x_q >= scr_w) || (y_q >= scr_h);

  // scan step: one table entry per cycle against the test point
  assign issue    = (ptr_q < count_q);
  assign step_hit = (x_q >= rd_rect.left) && (y_q >= rd_rect.top) &&
                    (x_q < rd_rect.right) && (y_q < rd_rect.bottom);

  // shrink the invisible rectangle around the point by one table entry
  always_comb begin
    grown = cache_q;
    if ((x_q < rd_rect.left) && (rd_rect.left <= cache_q.max_x)) begin
      grown.max_x = coord_t'(rd_rect.left - CoordOne);
    end
    if ((x_q >= rd_rect.right) && (rd_rect.right > cache_q.min_x)) begin
      grown.min_x = rd_rect.right;
    end
    if ((y_q < rd_rect.top) && (rd_rect.top <= cache_q.max_y)) begin
      grown.max_y = coord_t'(rd_rect.top - CoordOne);
    end
    if ((y_q >= rd_rect.bottom) && (rd_rect.bottom > cache_q.min_y)) begin
      grown.min_y = rd_rect.bottom;
    end
  end

  // table write straight from the request word; reads follow the scan pointer,
  // entry 0 is read while idle so a set-count word finds it ready in the load0 state
  assign ram_we    = acc && (req_op_e'(req_i.req_type) == OP_WRITE_RECT) &&
                     (int'(req_i.rect_index) < MaxRects);
  assign ram_waddr = RectIdxW'(req_i.rect_index);
  assign ram_wdata = '{left: req_i.rect_left, top: req_i.rect_top,
                       right: req_i.rect_right, bottom: req_i.rect_bottom};
  assign ram_raddr = ((state_q == ST_HIT) || (state_q == ST_GROW)) ? ptr_q[RectIdxW-1:0]
                                                                    : '0;

  ccpa_ram #(
    .Width (RectW),
    .Depth (MaxRects)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (rd_rect)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (acc) begin
          case (req_op_e'(req_i.req_type))
            OP_WRITE_RECT: state_d = ST_DONE;
            OP_SET_COUNT:  state_d = (cnt_sat == '0) ? ST_DONE : ST_LOAD0;
            default:       state_d = ST_CHECK;
          endcase
        end
      end
      ST_LOAD0: state_d = ST_DONE;
      ST_CHECK: begin
        if (cache_hit || off_screen || (count_q == '0)) begin
          state_d = ST_DONE;
        end else begin
          state_d = ST_HIT;
        end
      end
      ST_HIT: begin
        if (pend_q && step_hit) begin
          state_d = ST_DONE;
        end else if (pend_q && !issue) begin
          state_d = ST_GROW;
        end
      end
      ST_GROW: begin
        if (pend_q && !issue) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath and register updates
  always_comb begin
    count_d  = count_q;
    cache_d  = cache_q;
    ptr_d    = ptr_q;
    pend_d   = 1'b0;
    load_out = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (acc && (req_op_e'(req_i.req_type) == OP_SET_COUNT)) begin
          count_d = cnt_sat;
          if (cnt_sat == '0) begin
            cache_d = CacheReset;
          end
        end
      end
      ST_LOAD0: begin
        // entry 0 becomes the visible cache, empty edges stick at the minimum
        cache_d = '{min_x: rd_rect.left, min_y: rd_rect.top,
                    max_x: sat_dec(rd_rect.right), max_y: sat_dec(rd_rect.bottom),
                    visible: 1'b1};
      end
      ST_CHECK: begin
        ptr_d = '0;
        if (!cache_hit) begin
          if (x_q[CoordW-1]) begin
            cache_d = '{min_x: CoordMin, min_y: CoordMin, max_x: CoordNegOne,
                        max_y: CoordMax, visible: 1'b0};
          end else if (y_q[CoordW-1]) begin
            cache_d = '{min_x: CoordMin, min_y: CoordMin, max_x: CoordMax,
                        max_y: CoordNegOne, visible: 1'b0};
          end else if (x_q >= scr_w) begin
            cache_d = '{min_x: scr_w, min_y: CoordMin, max_x: CoordMax,
                        max_y: CoordMax, visible: 1'b0};
          end else if (y_q >= scr_h) begin
            cache_d = '{min_x: CoordMin, min_y: scr_h, max_x: CoordMax,
                        max_y: CoordMax, visible: 1'b0};
          end else if (count_q == '0) begin
            // no rectangles: the whole screen is visible
            cache_d = '{min_x: CoordZero, min_y: CoordZero,
                        max_x: coord_t'(scr_w - CoordOne), max_y: coord_t'(scr_h - CoordOne),
                        visible: 1'b1};
          end
        end
      end
      ST_HIT: begin
        ptr_d  = ptr_q + CountW'(issue);
        pend_d = issue;
        if (pend_q && step_hit) begin
          cache_d = '{min_x: rd_rect.left, min_y: rd_rect.top,
                      max_x: coord_t'(rd_rect.right - CoordOne),
                      max_y: coord_t'(rd_rect.bottom - CoordOne), visible: 1'b1};
        end else if (pend_q && !issue) begin
          // no hit: start the invisible rectangle from the whole plane
          cache_d = CacheReset;
          ptr_d   = '0;
          pend_d  = 1'b0;
        end
      end
      ST_GROW: begin
        ptr_d  = ptr_q + CountW'(issue);
        pend_d = issue;
        if (pend_q) begin
          cache_d = grown;
        end
      end
      ST_DONE: load_out = out_free;
      default: ;
    endcase
  end

  // result: a point test leaves its answer in the cache visibility,
  // an area test then looks up the second corner
  always_comb begin
    case (op_q)
      OP_CLIP_POINT: begin
        out_status_d = cache_q.visible ? STATUS_VISIBLE : STATUS_INVISIBLE;
      end
      OP_CLIP_AREA: begin
        if (in_box(cache_q, x2_q, y2_q)) begin
          out_status_d = cache_q.visible ? STATUS_VISIBLE : STATUS_INVISIBLE;
        end else begin
          out_status_d = STATUS_PARTIAL;
        end
      end
      default: out_status_d = STATUS_INVISIBLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.clip_status = out_status_q;

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      cache_q     <= CacheReset;
      ptr_q       <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
      width_q     <= ScreenWidthRst;
      height_q    <= ScreenHeightRst;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      cache_q     <= cache_d;
      ptr_q       <= ptr_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i && (cfg_reg_e'(cfg_idx_i) == CFG_SCREEN_WIDTH)) begin
        width_q <= cfg_wdata_i;
      end
      if (cfg_we_i && (cfg_reg_e'(cfg_idx_i) == CFG_SCREEN_HEIGHT)) begin
        height_q <= cfg_wdata_i;
      end
    end
  end

  // request word and result payload
  always_ff @(posedge clk_i) begin
    if (acc) begin
      op_q <= req_op_e'(req_i.req_type);
      x_q  <= req_i.x_first;
      y_q  <= req_i.y_first;
      x2_q <= req_i.x_second;
      y2_q <= req_i.y_second;
    end
    if (load_out) begin
      out_status_q <= out_status_d;
    end
  end

  `CCPA_ASSERT(a_ptr_bound, ((state_q == ST_HIT) || (state_q == ST_GROW)) |-> (ptr_q <= count_q), "scan pointer passed the rectangle count")
  `CCPA_ASSERT(a_count_bound, count_q <= CountW'(MaxRects), "rectangle count above table size")
  `CCPA_ASSERT_NEVER(a_scan_empty, ((state_q == ST_HIT) || (state_q == ST_GROW)) && (count_q == '0), "table scan with no rectangles")
  `CCPA_ASSERT(a_out_from_done, $rose(out_valid_q) |-> ($past(state_q) == ST_DONE), "result word not loaded from done state")

endmodule

### bench/tb_clip_cache_point_area_test.sv
// testbench of the clip cache point and area test: directed and random requests against a predictor
`timescale 1ns / 100ps

module tb_clip_cache_point_area_test;
  import ccpa_pkg::*;

  localparam int CoordLo   = int'(CoordMin);
  localparam int CoordHi   = int'(CoordMax);

  // one request word as the sender sees it
  typedef struct {
    req_op_e                op;
    logic [RectIdxFldW-1:0] index;
    rect_t                  rect;
    logic [RegionFldW-1:0]  count;
    coord_t                 x1;
    coord_t                 y1;
    coord_t                 x2;
    coord_t                 y2;
  } clip_req_t;

  // visibility predictor: own copy of the rectangle list, count, cache and screen size,
  // plus the queue of clip status words still owed by the block
  class visibility_tracker;
    rect_t        rects [MaxRects];
    bit           rect_loaded [MaxRects];
    int unsigned  live_rects;
    cache_t       cache;
    int           width;
    int           height;
    clip_status_e pending_status [$];
    int unsigned  mismatches;
    int unsigned  words_checked;

    function new();
      live_rects    = 0;
      width         = int'(ScreenWidthRst);
      height        = int'(ScreenHeightRst);
      mismatches    = 0;
      words_checked = 0;
      foreach (rect_loaded[i]) rect_loaded[i] = 1'b0;
      load_cache(CoordLo, CoordLo, CoordHi, CoordHi, 1'b0);
    endfunction

    function int sx(coord_t v);
      return int'($signed(v));
    endfunction

    function void load_cache(int x0, int y0, int x1, int y1, bit vis);
      cache.min_x   = coord_t'(x0);
      cache.min_y   = coord_t'(y0);
      cache.max_x   = coord_t'(x1);
      cache.max_y   = coord_t'(y1);
      cache.visible = vis;
    endfunction

    function bit cache_covers(int x, int y);
      return x >= sx(cache.min_x) && x <= sx(cache.max_x) &&
             y >= sx(cache.min_y) && y <= sx(cache.max_y);
    endfunction

    // point visibility; reloads the cache on every path but the cache hit
    function bit point_visible(int x, int y);
      rect_t q;
      int    lo_x, lo_y, hi_x, hi_y;
      if (cache_covers(x, y)) return cache.visible;
      if (x < 0) begin
        load_cache(CoordLo, CoordLo, -1, CoordHi, 1'b0);
        return 1'b0;
      end
      if (y < 0) begin
        load_cache(CoordLo, CoordLo, CoordHi, -1, 1'b0);
        return 1'b0;
      end
      if (x >= width) begin
        load_cache(width, CoordLo, CoordHi, CoordHi, 1'b0);
        return 1'b0;
      end
      if (y >= height) begin
        load_cache(CoordLo, height, CoordHi, CoordHi, 1'b0);
        return 1'b0;
      end
      if (live_rects == 0) begin
        load_cache(0, 0, width - 1, height - 1, 1'b1);
        return 1'b1;
      end
      for (int i = 0; i < live_rects; i++) begin
        q = rects[i];
        if (x >= sx(q.left) && y >= sx(q.top) && x < sx(q.right) && y < sx(q.bottom)) begin
          load_cache(sx(q.left), sx(q.top), sx(q.right) - 1, sx(q.bottom) - 1, 1'b1);
          return 1'b1;
        end
      end
      // miss: shrink the whole plane against every rectangle edge beyond the point
      lo_x = CoordLo;
      lo_y = CoordLo;
      hi_x = CoordHi;
      hi_y = CoordHi;
      for (int i = 0; i < live_rects; i++) begin
        q = rects[i];
        if (x < sx(q.left) && sx(q.left) <= hi_x) hi_x = sx(q.left) - 1;
        if (x >= sx(q.right) && sx(q.right) - 1 >= lo_x) lo_x = sx(q.right);
        if (y < sx(q.top) && sx(q.top) <= hi_y) hi_y = sx(q.top) - 1;
        if (y >= sx(q.bottom) && sx(q.bottom) - 1 >= lo_y) lo_y = sx(q.bottom);
      end
      load_cache(lo_x, lo_y, hi_x, hi_y, 1'b0);
      return 1'b0;
    endfunction

    function void note_request(clip_req_t r);
      clip_status_e status;
      rect_t        q;
      int           r_edge, b_edge;
      status = STATUS_INVISIBLE;
      case (r.op)
        OP_WRITE_RECT: begin
          rects[r.index]       = r.rect;
          rect_loaded[r.index] = 1'b1;
        end
        OP_SET_COUNT: begin
          live_rects = (r.count > MaxRects) ? MaxRects : r.count;
          if (live_rects == 0) begin
            load_cache(CoordLo, CoordLo, CoordHi, CoordHi, 1'b0);
          end else begin
            q      = rects[0];
            r_edge = sx(q.right) - 1;
            b_edge = sx(q.bottom) - 1;
            load_cache(sx(q.left), sx(q.top), (r_edge < CoordLo) ? CoordLo : r_edge,
                       (b_edge < CoordLo) ? CoordLo : b_edge, 1'b1);
          end
        end
        OP_CLIP_POINT: begin
          status = point_visible(sx(r.x1), sx(r.y1)) ? STATUS_VISIBLE : STATUS_INVISIBLE;
        end
        default: begin
          if (!cache_covers(sx(r.x1), sx(r.y1))) void'(point_visible(sx(r.x1), sx(r.y1)));
          if (cache_covers(sx(r.x2), sx(r.y2)))
            status = cache.visible ? STATUS_VISIBLE : STATUS_INVISIBLE;
          else
            status = STATUS_PARTIAL;
        end
      endcase
      pending_status.push_back(status);
    endfunction

    function void check_status(logic [1:0] got);
      clip_status_e want;
      words_checked++;
      if (pending_status.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected clip status word, expected none actual %0d", $time, got);
        return;
      end
      want = pending_status.pop_front();
      if (got !== want) begin
        mismatches++;
        $display("%0t: clip status mismatch, expected %0d (%s) actual %0d",
                 $time, want, want.name(), got);
      end
    endfunction

    function void set_screen(cfg_reg_e idx, int value);
      if (idx == CFG_SCREEN_WIDTH) width = value;
      else height = value;
    endfunction

    // entries 0 .. n-1 all written; a count never reaches past this
    function int unsigned loaded_prefix();
      int unsigned n;
      n = 0;
      while (n < MaxRects && rect_loaded[n]) n++;
      return n;
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_wdata_i;

  ccpa_req_if req_ch ();
  ccpa_rsp_if rsp_ch ();

  visibility_tracker vis = new();

  int unsigned burst_left;
  int unsigned items_sent;

  clip_cache_point_area_test u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req_ch),
    .rsp_o       (rsp_ch)
  );

  // 4 ns clock
  initial clk_i = 1'b0;
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // clamp into the coordinate range
  function automatic coord_t to_coord(int v);
    if (v < CoordLo) return CoordMin;
    if (v > CoordHi) return CoordMax;
    return coord_t'(v);
  endfunction

  // mostly just around the screen, sometimes anywhere, sometimes at the limits
  function automatic int pick_int(int span);
    case ($urandom_range(0, 15))
      0: return int'(coord_t'($urandom));
      1: begin
        case ($urandom_range(0, 3))
          0:       return CoordLo;
          1:       return CoordHi;
          2:       return 0;
          default: return -1;
        endcase
      end
      default: return int'($urandom_range(0, span + 8)) - 4;
    endcase
  endfunction

  function automatic int near(int v);
    return v + int'($urandom_range(0, 64)) - 32;
  endfunction

  function automatic rect_t box(int l, int t, int r, int b);
    rect_t q;
    q.left   = to_coord(l);
    q.top    = to_coord(t);
    q.right  = to_coord(r);
    q.bottom = to_coord(b);
    return q;
  endfunction

  // rectangle sized to the current screen, now and then empty or inverted
  function automatic rect_t shaped_rect();
    int l, t;
    l = pick_int(vis.width);
    t = pick_int(vis.height);
    if ($urandom_range(0, 9) == 0)
      return box(l, t, l - int'($urandom_range(0, 16)), t - int'($urandom_range(0, 16)));
    return box(l, t, l + 1 + int'($urandom_range(0, vis.width / 3 + 2)),
               t + 1 + int'($urandom_range(0, vis.height / 3 + 2)));
  endfunction

  // every field random, so unused fields toggle too
  function automatic clip_req_t blank_req();
    clip_req_t r;
    r.op    = req_op_e'($urandom_range(0, 3));
    r.index = RectIdxFldW'($urandom);
    r.rect  = rect_t'({$urandom, $urandom});
    r.count = RegionFldW'($urandom);
    r.x1    = coord_t'($urandom);
    r.y1    = coord_t'($urandom);
    r.x2    = coord_t'($urandom);
    r.y2    = coord_t'($urandom);
    return r;
  endfunction

  // count that only covers written entries; past the table once all are written
  function automatic int unsigned pick_count(int unsigned k);
    int unsigned p;
    p = vis.loaded_prefix();
    if (k != 0 && $urandom_range(0, 4) != 0) return k;
    if (p == MaxRects) return $urandom_range(0, (1 << RegionFldW) - 1);
    return $urandom_range(0, p);
  endfunction

  function automatic clip_req_t rect_req(int unsigned idx, rect_t q);
    clip_req_t r;
    r       = blank_req();
    r.op    = OP_WRITE_RECT;
    r.index = RectIdxFldW'(idx);
    r.rect  = q;
    return r;
  endfunction

  function automatic clip_req_t count_req(int unsigned n);
    clip_req_t r;
    r       = blank_req();
    r.op    = OP_SET_COUNT;
    r.count = RegionFldW'(n);
    return r;
  endfunction

  function automatic clip_req_t point_req(int x, int y);
    clip_req_t r;
    r    = blank_req();
    r.op = OP_CLIP_POINT;
    r.x1 = to_coord(x);
    r.y1 = to_coord(y);
    return r;
  endfunction

  function automatic clip_req_t area_req(int x1, int y1, int x2, int y2);
    clip_req_t r;
    r    = blank_req();
    r.op = OP_CLIP_AREA;
    r.x1 = to_coord(x1);
    r.y1 = to_coord(y1);
    r.x2 = to_coord(x2);
    r.y2 = to_coord(y2);
    return r;
  endfunction

  // any operation with wild content; a count still stays within written entries
  function automatic clip_req_t noise_req();
    clip_req_t r;
    r = blank_req();
    if (r.op == OP_SET_COUNT) r.count = RegionFldW'(pick_count(0));
    else if (r.op == OP_WRITE_RECT && $urandom_range(0, 1) == 1) r.rect = shaped_rect();
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // drivers
  // ---------------------------------------------------------------------------

  // offer one word and hold it until accepted; the sender runs in bursts with gaps
  task automatic offer(input clip_req_t r);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap        = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        req_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    req_ch.valid        <= 1'b1;
    req_ch.req_type     <= r.op;
    req_ch.rect_index   <= r.index;
    req_ch.rect_left    <= r.rect.left;
    req_ch.rect_top     <= r.rect.top;
    req_ch.rect_right   <= r.rect.right;
    req_ch.rect_bottom  <= r.rect.bottom;
    req_ch.region_count <= r.count;
    req_ch.x_first      <= r.x1;
    req_ch.y_first      <= r.y1;
    req_ch.x_second     <= r.x2;
    req_ch.y_second     <= r.y2;
    do @(posedge clk_i); while (!req_ch.ready);
    vis.note_request(r);
    items_sent++;
  endtask

  task automatic write_reg(input cfg_reg_e idx, input int unsigned value);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= CfgDataW'(value);
    @(posedge clk_i);
    vis.set_screen(idx, int'(value));
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // stop offering and wait for every owed status word
  task automatic drain();
    req_ch.valid <= 1'b0;
    while (vis.pending_status.size() != 0) @(posedge clk_i);
    @(posedge clk_i);
    burst_left = 0;
  endtask

  // scenes: load a fresh list, set the count, then a run of point and area probes
  task automatic run_phase(input int unsigned quota);
    int unsigned start, k;
    int          x, y;
    start = items_sent;
    while (items_sent - start < quota) begin
      k = $urandom_range(1, MaxRects);
      for (int unsigned i = 0; i < k; i++) offer(rect_req(i, shaped_rect()));
      offer(count_req(pick_count(k)));
      repeat ($urandom_range(8, 40)) begin
        case ($urandom_range(0, 7))
          0:       offer(noise_req());
          1, 2, 3: offer(point_req(pick_int(vis.width), pick_int(vis.height)));
          default: begin
            x = pick_int(vis.width);
            y = pick_int(vis.height);
            if ($urandom_range(0, 2) != 0) offer(area_req(x, y, near(x), near(y)));
            else offer(area_req(x, y, pick_int(vis.width), pick_int(vis.height)));
          end
        endcase
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // result side
  // ---------------------------------------------------------------------------

  // every accepted status word goes to the predictor
  always @(posedge clk_i) begin
    if (rst_ni && rsp_ch.valid && rsp_ch.ready) vis.check_status(rsp_ch.clip_status);
  end

  // receiver stalls on its own pattern; once, a long hold-off fills the block up
  initial begin : receiver
    int unsigned mode, stretch;
    bit          held_off;
    held_off = 1'b0;
    rsp_ch.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      mode    = $urandom_range(0, 3);
      stretch = $urandom_range(10, 60);
      if (!held_off && vis.words_checked >= 600) begin
        held_off = 1'b1;
        rsp_ch.ready <= 1'b0;
        repeat (300) @(posedge clk_i);
      end
      repeat (stretch) begin
        case (mode)
          0:       rsp_ch.ready <= 1'b1;
          1:       rsp_ch.ready <= ($urandom_range(0, 1) == 1);
          2:       rsp_ch.ready <= ($urandom_range(0, 3) == 0);
          default: rsp_ch.ready <= ($urandom_range(0, 7) != 0);
        endcase
        @(posedge clk_i);
      end
    end
  end

  // hard stop well past the slowest legal run
  initial begin : watchdog
    #2_000_000;
    $display("clip_cache_point_area_test verification failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int unsigned w, h;
    burst_left = 0;
    items_sent = 0;
    rst_ni              <= 1'b0;
    cfg_we_i            <= 1'b0;
    cfg_idx_i           <= CFG_SCREEN_WIDTH;
    cfg_wdata_i         <= '0;
    req_ch.valid        <= 1'b0;
    req_ch.req_type     <= OP_WRITE_RECT;
    req_ch.rect_index   <= '0;
    req_ch.rect_left    <= '0;
    req_ch.rect_top     <= '0;
    req_ch.rect_right   <= '0;
    req_ch.rect_bottom  <= '0;
    req_ch.region_count <= '0;
    req_ch.x_first      <= '0;
    req_ch.y_first      <= '0;
    req_ch.x_second     <= '0;
    req_ch.y_second     <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part on the 640 x 480 reset screen
    // after reset the cache spans the whole plane as invisible
    offer(point_req(100, 100));
    offer(area_req(CoordLo, CoordLo, CoordHi, CoordHi));
    // empty first rectangle: loaded cache edges stick at the low limit
    offer(rect_req(0, box(CoordLo, CoordLo, CoordLo, CoordLo)));
    offer(count_req(1));
    offer(point_req(CoordLo, CoordLo));
    // miss with nothing to shrink against
    offer(point_req(5, 5));
    offer(rect_req(0, box(10, 20, 200, 120)));
    offer(rect_req(1, box(300, 200, 640, 480)));
    offer(rect_req(2, box(-100, -50, 20, 30)));
    offer(rect_req(15, box(CoordHi, CoordHi, CoordHi, CoordHi)));
    offer(count_req(3));
    offer(point_req(50, 50));    // cache hit
    offer(point_req(400, 300));  // scan hit on entry 1
    offer(point_req(250, 150));  // miss, cache grows around the point
    // each screen half-plane
    offer(point_req(-1, 10));
    offer(point_req(10, -1));
    offer(point_req(640, 10));
    offer(point_req(10, 480));
    offer(point_req(639, 479));
    // area: whole inside, crossing an edge, outside everything
    offer(area_req(20, 30, 100, 100));
    offer(area_req(20, 30, 500, 400));
    offer(area_req(250, 150, 260, 160));
    offer(count_req(0));
    offer(point_req(CoordHi, CoordHi));

    // random phases, each on its own screen size, extremes and a zero size among them
    for (int p = 0; p < 9; p++) begin
      case (p)
        0:       begin w = 640;   h = 480;   end
        1:       begin w = 1;     h = 1;     end
        2:       begin w = 32767; h = 32767; end
        3:       begin w = 0;     h = 0;     end
        4:       begin w = 0;     h = 300;   end
        5:       begin w = 320;   h = 0;     end
        6:       begin w = 32767; h = 1;     end
        default: begin
          w = $urandom_range(1, 2000);
          h = $urandom_range(1, 2000);
        end
      endcase
      drain();
      write_reg(CFG_SCREEN_WIDTH, w);
      write_reg(CFG_SCREEN_HEIGHT, h);
      run_phase(195);
    end

    // let the last words out, then a margin past the longest scan
    drain();
    repeat (50) @(posedge clk_i);
    if (vis.mismatches == 0 && vis.pending_status.size() == 0) begin
      $display("clip_cache_point_area_test verification clean");
    end else begin
      $display("clip_cache_point_area_test verification failed");
    end
    $finish;
  end

endmodule
